FILE: rtl/core/amfs_pkg.sv
// Shared types, constants and the CRC16 byte update for the Modbus frame splitter.
`default_nettype none

package amfs_pkg;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_data;
      logic       read_slot;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [8:0] frame_len;
      logic       frame_slot;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       is_read;
      logic [7:0] rx_data;
      logic       read_slot;
      logic [7:0] read_offset;
   } cmd_type;

   localparam logic FUNC_RECEIVE = 1'b0;
   localparam logic FUNC_READ    = 1'b1;

   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_MODBUS = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] CSR_TEXT_MAX_LEN   = 2'd0;
   localparam logic [1:0] CSR_MODBUS_MAX_LEN = 2'd1;
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd2;

   localparam logic [8:0] TEXT_MAX_LEN_RESET   = 9'd128;
   localparam logic [8:0] MODBUS_MAX_LEN_RESET = 9'd256;
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;

   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] FC_READ  = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h10;

   localparam int unsigned READ_FRAME_LEN   = 8;
   localparam int unsigned WRITE_HEADER_LEN = 9;
   localparam int unsigned POS_ADDRESS      = 0;
   localparam int unsigned POS_FUNCTION     = 1;
   localparam int unsigned POS_BYTE_COUNT   = 6;
   localparam int unsigned MIN_TEXT_FILL    = 2;
   localparam int unsigned MIN_MODBUS_FILL  = 5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/amfs_front.sv
// Input side: accepts request words, classifies them and reduces the read index.
`default_nettype none

module amfs_front import amfs_pkg::*; #(
   parameter int BUF_LEN = 256
) (
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   logic [7:0] offset_table [256];

   for (genvar i = 0; i < 256; i++) begin : g_offset
      assign offset_table[i] = 8'(i % BUF_LEN);
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid & ~queue_full;

   always_comb begin
      push_cmd.is_read     = (req_data.func == FUNC_READ);
      push_cmd.rx_data     = req_data.rx_data;
      push_cmd.read_slot   = req_data.read_slot;
      push_cmd.read_offset = offset_table[req_data.read_index];
   end

endmodule

`default_nettype wire

FILE: rtl/core/amfs_queue.sv
// Two-entry command queue between the input side and the frame engine.
`default_nettype none

module amfs_queue import amfs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd,
   input  wire logic    pop
);

   localparam int DEPTH = 2;

   cmd_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'(DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count exceeds its depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

FILE: rtl/core/amfs_back.sv
// Frame engine: buffer memory, fill tracking, running CRC, frame decisions and result register.
`default_nettype none

module amfs_back import amfs_pkg::*; #(
   parameter int BUF_LEN = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire cmd_type    head_cmd,
   output logic            pop,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_wdata,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);

   localparam int FW = $clog2(BUF_LEN + 1);
   localparam int AW = $clog2(2 * BUF_LEN);
   localparam int CW = (FW > 10) ? FW : 10;

   logic [7:0] mem [2 * BUF_LEN];
   logic [7:0] read_data_ff;

   logic [FW-1:0] fill_ff, fill_in;
   logic          slot_ff, slot_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    fcode_ff, fcode_in;
   logic [7:0]    wbc_ff, wbc_in;
   logic [15:0]   crc0_ff, crc0_in;
   logic [15:0]   crc1_ff, crc1_in;
   logic [8:0]    text_max_ff, text_max_in;
   logic [8:0]    modbus_max_ff, modbus_max_in;
   logic [7:0]    dev_addr_ff, dev_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [8:0]    len_ff, len_in;
   logic          rslot_ff, rslot_in;

   logic          take, do_byte, do_read;
   logic          wrap, slot_cur;
   logic [FW-1:0] pos, fill_new;
   logic [7:0]    rx;
   logic [15:0]   crc_base;
   logic [CW-1:0] fill_x, wlen, chk_len, emit_len;
   logic          is_text, frame_ok, check, emit;
   logic [1:0]    emit_kind;
   logic [AW-1:0] wr_addr, rd_addr;

   assign csr_ready = 1'b1;
   assign take      = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop       = take;
   assign do_read   = take & head_cmd.is_read;
   assign do_byte   = take & ~head_cmd.is_read;

   assign rx       = head_cmd.rx_data;
   assign wrap     = (fill_ff == FW'(BUF_LEN));
   assign slot_cur = slot_ff ^ wrap;
   assign pos      = wrap ? '0 : fill_ff;
   assign fill_new = pos + FW'(1);
   assign fill_x   = CW'(fill_new);
   assign crc_base = (pos == FW'(POS_ADDRESS)) ? CRC_INIT : crc0_ff;

   assign wr_addr = slot_cur ? (AW'(BUF_LEN) + AW'(pos)) : AW'(pos);
   assign rd_addr = head_cmd.read_slot ? (AW'(BUF_LEN) + AW'(head_cmd.read_offset))
                                       : AW'(head_cmd.read_offset);

   always_comb begin
      first_in = (pos == FW'(POS_ADDRESS)) ? rx : first_ff;
      fcode_in = (pos == FW'(POS_FUNCTION)) ? rx : fcode_ff;
      wbc_in   = (pos == FW'(POS_BYTE_COUNT)) ? rx : wbc_ff;
      crc0_in  = crc16_byte(crc_base, rx);
      crc1_in  = crc0_ff;
      prev_in  = rx;
      wlen     = CW'(WRITE_HEADER_LEN) + CW'(wbc_in);
      is_text  = (fill_x >= CW'(MIN_TEXT_FILL)) && (prev_ff == BYTE_CR) && (rx == BYTE_LF);
      frame_ok = (crc1_ff == {rx, prev_ff});
   end

   always_comb begin
      fill_in   = fill_new;
      slot_in   = slot_cur;
      emit      = 1'b0;
      emit_kind = KIND_TEXT;
      emit_len  = '0;
      check     = 1'b0;
      chk_len   = CW'(READ_FRAME_LEN);
      if (is_text) begin
         fill_in = '0;
         if (fill_x <= CW'(text_max_ff)) begin
            emit     = 1'b1;
            emit_len = fill_x;
            slot_in  = ~slot_cur;
         end
      end else if ((fill_x >= CW'(MIN_MODBUS_FILL)) && (first_in == dev_addr_ff)) begin
         if (fcode_in == FC_READ) begin
            check   = 1'b1;
            chk_len = CW'(READ_FRAME_LEN);
         end else if ((fcode_in == FC_WRITE) && (fill_x > CW'(POS_BYTE_COUNT))) begin
            if ((wlen > CW'(BUF_LEN)) || (wlen > CW'(modbus_max_ff))) begin
               fill_in = '0;
            end else begin
               check   = 1'b1;
               chk_len = wlen;
            end
         end
      end
      if (check && (fill_x >= chk_len)) begin
         fill_in = '0;
         if ((fill_x == chk_len) && frame_ok) begin
            emit      = 1'b1;
            emit_kind = KIND_MODBUS;
            emit_len  = chk_len;
            slot_in   = ~slot_cur;
         end
      end
   end

   always_comb begin
      text_max_in   = text_max_ff;
      modbus_max_in = modbus_max_ff;
      dev_addr_in   = dev_addr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_MAX_LEN:   text_max_in   = csr_wdata;
            CSR_MODBUS_MAX_LEN: modbus_max_in = csr_wdata;
            CSR_DEVICE_ADDRESS: dev_addr_in   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      kind_in      = kind_ff;
      len_in       = len_ff;
      rslot_in     = rslot_ff;
      if (do_read) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_READ;
         len_in       = '0;
         rslot_in     = head_cmd.read_slot;
      end else if (do_byte) begin
         rsp_valid_in = emit;
         kind_in      = emit_kind;
         len_in       = 9'(emit_len);
         rslot_in     = slot_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         slot_ff       <= 1'b0;
         prev_ff       <= 8'h00;
         first_ff      <= 8'h00;
         fcode_ff      <= 8'h00;
         wbc_ff        <= 8'h00;
         crc0_ff       <= CRC_INIT;
         crc1_ff       <= CRC_INIT;
         text_max_ff   <= TEXT_MAX_LEN_RESET;
         modbus_max_ff <= MODBUS_MAX_LEN_RESET;
         dev_addr_ff   <= DEVICE_ADDRESS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (do_byte) begin
            fill_ff  <= fill_in;
            slot_ff  <= slot_in;
            prev_ff  <= prev_in;
            first_ff <= first_in;
            fcode_ff <= fcode_in;
            wbc_ff   <= wbc_in;
            crc0_ff  <= crc0_in;
            crc1_ff  <= crc1_in;
         end
         text_max_ff   <= text_max_in;
         modbus_max_ff <= modbus_max_in;
         dev_addr_ff   <= dev_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      len_ff   <= len_in;
      rslot_ff <= rslot_in;
   end

   always_ff @(posedge clock) begin
      if (do_byte) begin
         mem[wr_addr] <= rx;
      end
      if (do_read) begin
         read_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.result_kind  = kind_ff;
   assign rsp_data.frame_len    = len_ff;
   assign rsp_data.frame_slot   = rslot_ff;
   assign rsp_data.read_data    = (kind_ff == KIND_READ) ? read_data_ff : 8'h00;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(BUF_LEN))
      else $error("fill count ran past the buffer length");
   a_report_restarts: assert property (@(posedge clock) disable iff (reset)
      (do_byte && emit) |=> (fill_ff == '0))
      else $error("fill did not restart after a frame report");
   a_report_toggles: assert property (@(posedge clock) disable iff (reset)
      (do_byte && emit) |=> (slot_ff != $past(slot_cur)))
      else $error("buffer did not switch after a frame report");
   a_modbus_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == KIND_MODBUS)) |->
         ((len_ff == 9'(READ_FRAME_LEN)) || (len_ff >= 9'(WRITE_HEADER_LEN))))
      else $error("Modbus frame reported with an impossible length");

endmodule

`default_nettype wire

FILE: rtl/core/at_modbus_frame_splitter_core.sv
// Top level of the ping-pong Modbus RTU and text frame splitter.
//
//   Port group   Direction  Handshake               Word
//   req_*        in         req_valid / req_stall   req_type: receive byte or buffer read
//   rsp_*        out        rsp_valid / rsp_stall   rsp_type: frame report or read data
//   csr_*        in         csr_valid / csr_ready   register index and write data
//
// One request word is accepted per cycle while the queue is not full; the frame engine handles one word per
// cycle unless a valid result is stalled. An accepted word is first written into the queue; the frame engine
// then takes it from the queue head and writes its result into the result register.
// The byte-wide CRC update and the length compares of the frame engine set the cycle time.
// Reset is synchronous; the buffer memory is not cleared and needs no startup pass.
// A stalled result holds the engine; the two-entry queue then fills and raises req_stall.
`default_nettype none

module at_modbus_frame_splitter_core import amfs_pkg::*; #(
   parameter int BUF_LEN = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_wdata
);

   logic    queue_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   amfs_front #(
      .BUF_LEN (BUF_LEN)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   amfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   amfs_back #(
      .BUF_LEN (BUF_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/amfs_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class and Modbus CRC helper for the frame splitter testbench.
package amfs_tb_pkg;
   import amfs_pkg::*;

   localparam int unsigned BUF_BYTES = 256;
   localparam logic [1:0]  CSR_SPARE = 2'd3;

   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] acc;
      acc = crc;
      for (int k = 0; k < 8; k++) begin
         if (acc[0] ^ data[k]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   class frame_scoreboard;
      logic [8:0]  text_limit;
      logic [8:0]  modbus_limit;
      logic [7:0]  dev_address;
      logic [7:0]  buffer_bytes [2*BUF_BYTES];
      bit          byte_written [2*BUF_BYTES];
      int unsigned fill;
      bit          fill_slot;
      logic [7:0]  last_byte;
      logic [7:0]  address_byte;
      logic [7:0]  function_byte;
      logic [7:0]  count_byte;
      logic [15:0] crc_trail [3];
      rsp_type     expected_reports [$];
      int unsigned mismatches;
      int unsigned text_frames;
      int unsigned modbus_frames;
      int unsigned buffer_reads;

      function new();
         text_limit    = TEXT_MAX_LEN_RESET;
         modbus_limit  = MODBUS_MAX_LEN_RESET;
         dev_address   = DEVICE_ADDRESS_RESET;
         fill          = 0;
         fill_slot     = 1'b0;
         last_byte     = 8'h00;
         address_byte  = 8'h00;
         function_byte = 8'h00;
         count_byte    = 8'h00;
         mismatches    = 0;
         text_frames   = 0;
         modbus_frames = 0;
         buffer_reads  = 0;
         foreach (crc_trail[i]) begin
            crc_trail[i] = CRC_INIT;
         end
         foreach (byte_written[i]) begin
            byte_written[i] = 1'b0;
            buffer_bytes[i] = 8'h00;
         end
      endfunction

      function void write_register(input logic [1:0] index, input logic [8:0] value);
         case (index)
            CSR_TEXT_MAX_LEN:   text_limit = value;
            CSR_MODBUS_MAX_LEN: modbus_limit = value;
            CSR_DEVICE_ADDRESS: dev_address = value[7:0];
            default: ;
         endcase
      endfunction

      function bit is_written(input bit slot, input logic [7:0] index);
         return byte_written[int'(slot) * BUF_BYTES + int'(index) % BUF_BYTES];
      endfunction

      function void queue_report(input logic [1:0] kind, input int unsigned len,
                                 input bit slot, input logic [7:0] data);
         rsp_type r;
         r.result_kind = kind;
         r.frame_len   = 9'(len);
         r.frame_slot  = slot;
         r.read_data   = data;
         expected_reports.push_back(r);
      endfunction

      function void predict_word(input req_type word);
         int unsigned pos;
         int unsigned filled;
         int unsigned need;
         int unsigned at;
         bit          slot;
         logic [7:0]  prior;
         logic [15:0] seed;
         if (word.func == FUNC_READ) begin
            at = int'(word.read_slot) * BUF_BYTES + int'(word.read_index) % BUF_BYTES;
            queue_report(KIND_READ, 0, word.read_slot, buffer_bytes[at]);
            buffer_reads++;
            return;
         end
         if (fill >= BUF_BYTES) begin
            fill_slot = ~fill_slot;
            fill = 0;
         end
         pos = fill;
         slot = fill_slot;
         at = int'(slot) * BUF_BYTES + pos;
         buffer_bytes[at] = word.rx_data;
         byte_written[at] = 1'b1;
         filled = pos + 1;
         fill = filled;
         if (pos == POS_ADDRESS) address_byte = word.rx_data;
         if (pos == POS_FUNCTION) function_byte = word.rx_data;
         if (pos == POS_BYTE_COUNT) count_byte = word.rx_data;
         seed = (pos == POS_ADDRESS) ? CRC_INIT : crc_trail[0];
         crc_trail[2] = crc_trail[1];
         crc_trail[1] = crc_trail[0];
         crc_trail[0] = modbus_crc_byte(seed, word.rx_data);
         prior = last_byte;
         last_byte = word.rx_data;

         if (filled >= MIN_TEXT_FILL && prior == BYTE_CR && word.rx_data == BYTE_LF) begin
            fill = 0;
            if (filled <= text_limit) begin
               queue_report(KIND_TEXT, filled, slot, 8'h00);
               text_frames++;
               fill_slot = ~fill_slot;
            end
            return;
         end

         if (filled < MIN_MODBUS_FILL || address_byte != dev_address) return;
         if (function_byte == FC_READ) begin
            need = READ_FRAME_LEN;
         end else if (function_byte == FC_WRITE) begin
            if (filled <= POS_BYTE_COUNT) return;
            need = WRITE_HEADER_LEN + count_byte;
            if (need > BUF_BYTES || need > modbus_limit) begin
               fill = 0;
               return;
            end
         end else begin
            return;
         end

         if (filled < need) return;
         fill = 0;
         if (filled == need && crc_trail[2] == {word.rx_data, prior}) begin
            queue_report(KIND_MODBUS, need, slot, 8'h00);
            modbus_frames++;
            fill_slot = ~fill_slot;
         end
      endfunction

      function void check_report(input rsp_type got);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected report: kind %0d, len %0d, slot %0d, data 0x%02h",
                   got.result_kind, got.frame_len, got.frame_slot, got.read_data);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
            mismatches++;
         end
         if (got.frame_len !== want.frame_len) begin
            $error("frame_len: expected %0d, actual %0d", want.frame_len, got.frame_len);
            mismatches++;
         end
         if (got.frame_slot !== want.frame_slot) begin
            $error("frame_slot: expected %0d, actual %0d", want.frame_slot, got.frame_slot);
            mismatches++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, got.read_data);
            mismatches++;
         end
      endfunction
   endclass

endpackage

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top-level testbench that drives the frame splitter core and checks its reports.
module tb;
   import amfs_pkg::*;
   import amfs_tb_pkg::*;

   localparam int unsigned RANDOM_WORDS  = 800;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;

   bit              steady = 1'b0;
   int unsigned     words_sent = 0;
   int unsigned     settings_used = 1;
   frame_scoreboard sb = new();

   at_modbus_frame_splitter_core #(.BUF_LEN(BUF_BYTES)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_report(rsp_data);
      end
      rsp_stall <= !steady && ($urandom_range(99) < 14);
   end

   task automatic push_word(input req_type word);
      while (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      sb.predict_word(word);
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      req_type word;
      word.func       = FUNC_RECEIVE;
      word.rx_data    = value;
      word.read_slot  = 1'($urandom);
      word.read_index = 8'($urandom);
      push_word(word);
   endtask

   task automatic send_read(input bit slot, input logic [7:0] index);
      req_type word;
      word.func       = FUNC_READ;
      word.rx_data    = 8'($urandom);
      word.read_slot  = slot;
      word.read_index = index;
      push_word(word);
   endtask

   task automatic read_back();
      bit         slot;
      logic [7:0] index;
      for (int tries = 0; tries < 16; tries++) begin
         slot = 1'($urandom);
         index = 8'($urandom);
         if (sb.is_written(slot, index)) begin
            send_read(slot, index);
            return;
         end
      end
   endtask

   // CR LF always ends the fill, whether it is reported or dropped.
   task automatic align_fill();
      while (sb.fill != 0 && sb.fill < BUF_BYTES) begin
         send_byte(BYTE_CR);
         send_byte(BYTE_LF);
      end
   endtask

   task automatic send_noise(input int unsigned len);
      repeat (len) send_byte(8'($urandom));
   endtask

   task automatic send_text(input int unsigned len);
      logic [7:0] value;
      align_fill();
      for (int i = 0; i + 2 < len; i++) begin
         value = 8'($urandom);
         if (value == BYTE_CR) value = 8'h2E;
         send_byte(value);
      end
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
   endtask

   task automatic send_modbus(input logic [7:0] address, input logic [7:0] fcode,
                              input logic [7:0] count, input bit corrupt);
      logic [7:0]  body [$];
      logic [15:0] crc;
      body.push_back(address);
      body.push_back(fcode);
      repeat (4) body.push_back(8'($urandom));
      if (fcode == FC_WRITE) begin
         body.push_back(count);
         repeat (count) body.push_back(8'($urandom));
      end
      crc = CRC_INIT;
      foreach (body[i]) begin
         crc = modbus_crc_byte(crc, body[i]);
      end
      if (corrupt) crc ^= 16'(1 << $urandom_range(15));
      align_fill();
      foreach (body[i]) begin
         send_byte(body[i]);
      end
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [8:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      sb.write_register(index, value);
      csr_valid <= 1'b0;
   endtask

   // A request for the new address is left open under the old one, so the first
   // byte after the change lands past its end and the fill is dropped.
   task automatic retarget(input logic [8:0] text_max, input logic [8:0] modbus_max,
                           input logic [7:0] address);
      align_fill();
      send_byte(address);
      send_byte(FC_READ);
      repeat ($urandom_range(10, 7)) send_byte(8'($urandom) | 8'h80);
      write_register(CSR_TEXT_MAX_LEN, text_max);
      write_register(CSR_MODBUS_MAX_LEN, modbus_max);
      write_register(CSR_DEVICE_ADDRESS, address);
      send_byte(8'($urandom) | 8'h80);
      settings_used++;
   endtask

   task automatic run_phase(input int unsigned words);
      int unsigned stop;
      int unsigned pick;
      int          count;
      int          len;
      logic [7:0]  fcode;
      stop = words_sent + words;
      while (words_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_modbus(sb.dev_address, FC_READ, 8'h00, $urandom_range(9) == 0);
         end else if (pick < 50) begin
            case ($urandom_range(19))
               15, 16, 17, 18: begin
                  count = int'(sb.modbus_limit) - int'(WRITE_HEADER_LEN)
                          + int'($urandom_range(2)) - 1;
               end
               19: count = int'($urandom_range(255));
               default: count = int'($urandom_range(12));
            endcase
            if (count < 0) count = 0;
            if (count > 255) count = 255;
            send_modbus(sb.dev_address, FC_WRITE, 8'(count), $urandom_range(9) == 0);
         end else if (pick < 62) begin
            if ($urandom_range(4) == 0) begin
               len = int'(sb.text_limit) + int'($urandom_range(2)) - 1;
            end else begin
               len = int'($urandom_range(16, 2));
            end
            if (len < 2) len = 2;
            send_text(len);
         end else if (pick < 70) begin
            if ($urandom_range(1) == 0) begin
               fcode = $urandom_range(1) ? FC_READ : FC_WRITE;
               send_modbus(sb.dev_address ^ 8'($urandom_range(255, 1)), fcode,
                           8'($urandom_range(8)), 1'b0);
            end else begin
               fcode = 8'($urandom);
               if (fcode == FC_READ || fcode == FC_WRITE) fcode = 8'h04;
               send_modbus(sb.dev_address, fcode, 8'h00, 1'b0);
            end
         end else if (pick < 78) begin
            send_noise($urandom_range(12, 1));
         end else if (pick < 80) begin
            send_noise($urandom_range(270, 100));
         end else begin
            repeat ($urandom_range(4, 1)) read_back();
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_modbus(DEVICE_ADDRESS_RESET, FC_READ, 8'h00, 1'b0);
      send_read(1'b0, 8'd0);
      send_read(1'b0, 8'd7);
      send_text(2);
      send_modbus(DEVICE_ADDRESS_RESET, FC_WRITE, 8'h00, 1'b0);
      send_read(1'b1, 8'd1);
      drain();

      send_noise(270);
      run_phase(RANDOM_WORDS / 5);
      retarget(9'd256, 9'd256, 8'hFF);
      steady = 1'b1;
      run_phase(RANDOM_WORDS / 5);
      steady = 1'b0;
      retarget(9'd2, 9'd9, 8'h00);
      run_phase(RANDOM_WORDS / 5);
      retarget(9'd1, 9'd40, 8'($urandom));
      run_phase(RANDOM_WORDS / 5);
      retarget(9'd64, 9'd120, 8'h01);
      write_register(CSR_SPARE, 9'($urandom));
      run_phase(RANDOM_WORDS / 5);
      drain();

      $display("Sent %0d request words across %0d register settings.",
               words_sent, settings_used);
      $display("Checked %0d text frames, %0d Modbus frames and %0d buffer reads.",
               sb.text_frames, sb.modbus_frames, sb.buffer_reads);
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: at_modbus_frame_splitter_core.f
rtl/core/amfs_pkg.sv
rtl/core/amfs_front.sv
rtl/core/amfs_queue.sv
rtl/core/amfs_back.sv
rtl/core/at_modbus_frame_splitter_core.sv
verif/amfs_tb_pkg.sv
verif/tb.sv
